// ===== design/cursor_overlay_blend_unit_macros.svh =====
// Assertion macros for the cursor overlay blend unit.
// They expect clk and rst_n in the enclosing module.
`ifndef CURSOR_OVERLAY_BLEND_UNIT_MACROS_SVH
`define CURSOR_OVERLAY_BLEND_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define COB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define COB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define COB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define COB_ASSERT(lbl, cond, msg)

`define COB_ASSERT_IMP(lbl, ante, cons, msg)

`define COB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/cob_pkg.sv =====
`default_nettype none

package cob_pkg;

  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam int POS_W = 13;
  localparam int DIM_W = 7;
  localparam int BG_W  = 24;
  localparam int TEX_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_FORMAT = 3'd4,
    REG_KIND   = 3'd5
  } reg_idx_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic FMT_BGR24  = 1'b0;
  localparam logic FMT_RGB555 = 1'b1;

  localparam logic KIND_ALPHA = 1'b0;
  localparam logic KIND_MASK  = 1'b1;

  localparam logic [7:0]      ALPHA_MAX   = 8'd255;
  localparam logic [BG_W-1:0] FULL_BGR24  = 24'hFF_FFFF;
  localparam logic [BG_W-1:0] FULL_RGB555 = 24'h00_FFFF;
  localparam logic [15:0]     RGB555_TOP  = 16'h8000;

  localparam logic [DIM_W-1:0] RESET_DIM = 7'd32;

  typedef struct packed {
    logic signed [POS_W-1:0] cur_left;
    logic signed [POS_W-1:0] cur_top;
    logic [DIM_W-1:0]        cur_width;
    logic [DIM_W-1:0]        cur_height;
    logic                    pix_fmt;
    logic                    cur_kind;
  } cob_cfg_t;

endpackage

`default_nettype wire

// ===== design/cob_ram.sv =====
`default_nettype none

module cob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/cob_cfg.sv =====
`default_nettype none

module cob_cfg
  import cob_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      cob_cfg_t           cfg
);

  cob_cfg_t cfg_r;
  cob_cfg_t cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LEFT:   cfg_nxt.cur_left   = signed'(pwdata[POS_W-1:0]);
        REG_TOP:    cfg_nxt.cur_top    = signed'(pwdata[POS_W-1:0]);
        REG_WIDTH:  cfg_nxt.cur_width  = pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.cur_height = pwdata[DIM_W-1:0];
        REG_FORMAT: cfg_nxt.pix_fmt    = pwdata[0];
        REG_KIND:   cfg_nxt.cur_kind   = pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cur_left   <= '0;
      cfg_r.cur_top    <= '0;
      cfg_r.cur_width  <= RESET_DIM;
      cfg_r.cur_height <= RESET_DIM;
      cfg_r.pix_fmt    <= FMT_BGR24;
      cfg_r.cur_kind   <= KIND_ALPHA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LEFT:   prdata = PDATA_W'(unsigned'(cfg_r.cur_left));
      REG_TOP:    prdata = PDATA_W'(unsigned'(cfg_r.cur_top));
      REG_WIDTH:  prdata = PDATA_W'(cfg_r.cur_width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_r.cur_height);
      REG_FORMAT: prdata = PDATA_W'(cfg_r.pix_fmt);
      REG_KIND:   prdata = PDATA_W'(cfg_r.cur_kind);
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/cob_blend.sv =====
`default_nettype none

module cob_blend
  import cob_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire cob_cfg_t         cfg,
  input  wire logic             in_vld,
  input  wire logic             in_cov,
  input  wire logic [TEX_W-1:0] texel,
  input  wire logic [BG_W-1:0]  bg,
  output      logic             res_vld,
  output      logic [BG_W-1:0]  res_pixel,
  output      logic             res_cov
);

  // stage 3: channel products and mask result
  logic            v3_r;
  logic            cov3_r;
  logic [BG_W-1:0] bg3_r;
  logic [BG_W-1:0] mask3_r;
  logic [15:0]     sum3_r  [3];
  logic [15:0]     sum_nxt [3];
  logic [BG_W-1:0] mask_nxt;

  // stage 4: output register
  logic            out_vld_r;
  logic            out_cov_r;
  logic [BG_W-1:0] out_pix_r;
  logic [BG_W-1:0] pix_nxt;

  always_comb begin
    logic [7:0]      a;
    logic [7:0]      c;
    logic [7:0]      b;
    logic [BG_W-1:0] full;
    a = texel[31:24];
    for (int i = 0; i < 3; i++) begin
      if (cfg.pix_fmt == FMT_RGB555) begin
        c = {3'b000, texel[8*i+3 +: 5]};
        b = {3'b000, bg[5*i +: 5]};
      end else begin
        c = texel[8*i +: 8];
        b = bg[8*i +: 8];
      end
      sum_nxt[i] = 16'(a * c) + 16'((ALPHA_MAX - a) * b);
    end
    full     = (cfg.pix_fmt == FMT_RGB555) ? FULL_RGB555 : FULL_BGR24;
    mask_nxt = ((bg & full & {BG_W{texel[0]}}) ^ {BG_W{texel[1]}}) & full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov3_r  <= in_cov;
      bg3_r   <= bg;
      mask3_r <= mask_nxt;
      for (int i = 0; i < 3; i++) begin
        sum3_r[i] <= sum_nxt[i];
      end
    end
  end

  // floor(s/255) for s up to 255*255
  always_comb begin
    logic [16:0] t;
    logic [7:0]  q [3];
    for (int i = 0; i < 3; i++) begin
      t    = 17'(sum3_r[i]) + 17'd1 + 17'(sum3_r[i] >> 8);
      q[i] = t[15:8];
    end
    if (!cov3_r) begin
      pix_nxt = bg3_r;
    end else if (cfg.cur_kind == KIND_MASK) begin
      pix_nxt = mask3_r;
    end else if (cfg.pix_fmt == FMT_RGB555) begin
      pix_nxt = BG_W'(RGB555_TOP | {1'b0, q[2][4:0], q[1][4:0], q[0][4:0]});
    end else begin
      pix_nxt = {q[2], q[1], q[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cov_r <= cov3_r;
      out_pix_r <= pix_nxt;
    end
  end

  assign res_vld   = out_vld_r;
  assign res_pixel = out_pix_r;
  assign res_cov   = out_cov_r;

endmodule

`default_nettype wire

// ===== design/cursor_overlay_blend_unit.sv =====
// Hardware cursor overlay. Load transactions (op 0) write one entry of a
// CURSOR_SIDE x CURSOR_SIDE image RAM; pixel transactions (op 1) come back
// one per transaction, in order, on out_valid after stages 1 to 3 and the
// stage-4 output register, either unchanged (outside the cursor) or alpha-blended /
// AND-XOR masked with the image entry under them. A new transaction is taken
// every clock; the only hold-off is out_stall backing up the four-stage
// pipeline. Image entries are undefined until loaded and must be written
// before any covered pixel reads them. Change registers only while the
// pipeline is empty.
`default_nettype none
`include "cursor_overlay_blend_unit_macros.svh"

module cursor_overlay_blend_unit
  import cob_pkg::*;
#(
  parameter int CURSOR_SIDE = 64,
  parameter int COORD_BITS  = 12
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       in_valid,
  output      logic                                       in_stall,
  input  wire logic                                       in_op,
  input  wire logic [$clog2(CURSOR_SIDE*CURSOR_SIDE)-1:0] in_image_index,
  input  wire logic [TEX_W-1:0]                           in_image_data,
  input  wire logic [COORD_BITS-1:0]                      in_pixel_x,
  input  wire logic [COORD_BITS-1:0]                      in_pixel_y,
  input  wire logic [BG_W-1:0]                            in_background,
  output      logic                                       out_valid,
  input  wire logic                                       out_stall,
  output      logic [BG_W-1:0]                            out_pixel,
  output      logic                                       out_covered,
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [PADDR_W-1:0]                         paddr,
  input  wire logic [PDATA_W-1:0]                         pwdata,
  output      logic [PDATA_W-1:0]                         prdata,
  output      logic                                       pready
);

  localparam int DEPTH  = CURSOR_SIDE * CURSOR_SIDE;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SB     = $clog2(CURSOR_SIDE);
  localparam int DIFF_W = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;

  cob_cfg_t cfg;
  logic     en;

  cob_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: offsets into the cursor
  logic              v1_r;
  logic              op1_r;
  logic              ld_ok1_r;
  logic [IDX_W-1:0]  idx1_r;
  logic [TEX_W-1:0]  data1_r;
  logic [BG_W-1:0]   bg1_r;
  logic [DIFF_W-1:0] dx1_r;
  logic [DIFF_W-1:0] dy1_r;
  logic [DIFF_W-1:0] dx_nxt;
  logic [DIFF_W-1:0] dy_nxt;
  logic              ld_ok_nxt;

  always_comb begin
    dx_nxt = DIFF_W'(in_pixel_x)
           - {{(DIFF_W-POS_W){cfg.cur_left[POS_W-1]}}, cfg.cur_left};
    dy_nxt = DIFF_W'(in_pixel_y)
           - {{(DIFF_W-POS_W){cfg.cur_top[POS_W-1]}}, cfg.cur_top};
    ld_ok_nxt = (32'(in_image_index) < 32'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= in_op;
      ld_ok1_r <= ld_ok_nxt;
      idx1_r   <= in_image_index;
      data1_r  <= in_image_data;
      bg1_r    <= in_background;
      dx1_r    <= dx_nxt;
      dy1_r    <= dy_nxt;
    end
  end

  // stage 2: cover test, image RAM access
  logic             cov_nxt;
  logic [IDX_W-1:0] raddr;
  logic             ram_we;
  logic             ram_re;
  logic [TEX_W-1:0] texel2;
  logic             v2_r;
  logic             cov2_r;
  logic [BG_W-1:0]  bg2_r;

  always_comb begin
    cov_nxt = !dx1_r[DIFF_W-1] && !dy1_r[DIFF_W-1]
           && (dx1_r < DIFF_W'(cfg.cur_width))  && (dx1_r < DIFF_W'(CURSOR_SIDE))
           && (dy1_r < DIFF_W'(cfg.cur_height)) && (dy1_r < DIFF_W'(CURSOR_SIDE));
    raddr   = IDX_W'(IDX_W'(dy1_r[SB-1:0]) * IDX_W'(CURSOR_SIDE)) + IDX_W'(dx1_r[SB-1:0]);
    ram_we  = en && v1_r && (op1_r == OP_LOAD) && ld_ok1_r;
    ram_re  = en && v1_r && (op1_r == OP_PIXEL);
  end

  cob_ram #(
    .WIDTH (TEX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx1_r),
    .wdata (data1_r),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (texel2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r && (op1_r == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov2_r <= cov_nxt;
      bg2_r  <= bg1_r;
    end
  end

  // stages 3 and 4
  cob_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_vld    (v2_r),
    .in_cov    (cov2_r),
    .texel     (texel2),
    .bg        (bg2_r),
    .res_vld   (out_valid),
    .res_pixel (out_pixel),
    .res_cov   (out_covered)
  );

  `COB_ASSERT_NEXT(a_load_no_result, en && v1_r && (op1_r == OP_LOAD), !v2_r,
                   "load transaction produced a result slot")
  `COB_ASSERT_NEXT(a_stall_keeps_slot, v2_r && !en, v2_r && $stable(bg2_r),
                   "stage 2 lost its transaction under stall")
  `COB_ASSERT_NEXT(a_uncovered_passes, en && v2_r && !cov2_r, !u_blend.cov3_r,
                   "uncovered pixel marked covered")
  `COB_ASSERT_IMP(a_rgb555_top_bit,
                  out_valid && out_covered && (cfg.pix_fmt == FMT_RGB555)
                    && (cfg.cur_kind == KIND_ALPHA),
                  out_pixel[15] && (out_pixel[BG_W-1:16] == '0),
                  "RGB555 blend result malformed")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cob_pkg::*;

  localparam int SIDE = 64;
  localparam int DEPTH = SIDE * SIDE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int COORD_W = 12;
  localparam int N_SETTINGS = 9;
  localparam int RANDOM_PER_SETTING = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   image_index;
    logic [TEX_W-1:0]   image_data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BG_W-1:0]    bg;
  } overlay_txn_t;

  typedef struct packed {
    logic            covered;
    logic [BG_W-1:0] pixel;
  } composite_t;

  typedef struct {
    int   left;
    int   top;
    int   width;
    int   height;
    logic fmt;
    logic kind;
    int   idle_pct;
    int   stall_pct;
  } setting_t;

  class overlay_scoreboard;
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] top;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic                    fmt;
    logic                    kind;
    logic [TEX_W-1:0]        image [DEPTH];
    composite_t              awaited [$];
    int errors;
    int loads_seen;
    int checked;
    int covered_hits;

    function new();
      left = '0;
      top = '0;
      width = RESET_DIM;
      height = RESET_DIM;
      fmt = FMT_BGR24;
      kind = KIND_ALPHA;
    endfunction

    function void set_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
      case (r)
        REG_LEFT:   left = v[POS_W-1:0];
        REG_TOP:    top = v[POS_W-1:0];
        REG_WIDTH:  width = v[DIM_W-1:0];
        REG_HEIGHT: height = v[DIM_W-1:0];
        REG_FORMAT: fmt = v[0];
        REG_KIND:   kind = v[0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      return int'(width) > SIDE ? SIDE : int'(width);
    endfunction

    function int eff_height();
      return int'(height) > SIDE ? SIDE : int'(height);
    endfunction

    function bit lookup(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, output int entry);
      int dx;
      int dy;
      dx = int'(x) - int'(left);
      dy = int'(y) - int'(top);
      entry = 0;
      if (dx < 0 || dy < 0 || dx >= eff_width() || dy >= eff_height()) return 1'b0;
      entry = dy * SIDE + dx;
      return 1'b1;
    endfunction

    function int mix(int a, int c, int b);
      return (a * c + (int'(ALPHA_MAX) - a) * b) / int'(ALPHA_MAX);
    endfunction

    function logic [BG_W-1:0] alpha_blend(logic [TEX_W-1:0] t, logic [BG_W-1:0] bg);
      int a;
      int r;
      int g;
      int b;
      a = t[31:24];
      if (fmt == FMT_BGR24) begin
        r = mix(a, t[7:0], bg[7:0]);
        g = mix(a, t[15:8], bg[15:8]);
        b = mix(a, t[23:16], bg[23:16]);
        return {b[7:0], g[7:0], r[7:0]};
      end
      r = mix(a, t[7:3], bg[4:0]);
      g = mix(a, t[15:11], bg[9:5]);
      b = mix(a, t[23:19], bg[14:10]);
      return BG_W'(RGB555_TOP) | {9'd0, b[4:0], g[4:0], r[4:0]};
    endfunction

    function logic [BG_W-1:0] mask_apply(logic [TEX_W-1:0] t, logic [BG_W-1:0] bg);
      logic [BG_W-1:0] full;
      logic [BG_W-1:0] andm;
      logic [BG_W-1:0] xorm;
      full = (fmt == FMT_BGR24) ? FULL_BGR24 : FULL_RGB555;
      andm = t[0] ? full : '0;
      xorm = t[1] ? full : '0;
      return ((bg & full & andm) ^ xorm) & full;
    endfunction

    function void note_item(overlay_txn_t t);
      composite_t res;
      int entry;
      if (t.op == OP_LOAD) begin
        image[t.image_index] = t.image_data;
        loads_seen++;
        return;
      end
      res.covered = lookup(t.x, t.y, entry);
      if (!res.covered) res.pixel = t.bg;
      else if (kind == KIND_ALPHA) res.pixel = alpha_blend(image[entry], t.bg);
      else res.pixel = mask_apply(image[entry], t.bg);
      awaited.push_back(res);
    endfunction

    function void check_result(logic [BG_W-1:0] pixel, logic covered);
      composite_t exp_res;
      if (awaited.size() == 0) begin
        $error("out_pixel %06h arrived with no pixel transaction outstanding", pixel);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      checked++;
      if (exp_res.covered) covered_hits++;
      if (pixel !== exp_res.pixel) begin
        $error("out_pixel: expected %06h, got %06h", exp_res.pixel, pixel);
        errors++;
      end
      if (covered !== exp_res.covered) begin
        $error("out_covered: expected %0b, got %0b", exp_res.covered, covered);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic [IDX_W-1:0]   in_image_index;
  logic [TEX_W-1:0]   in_image_data;
  logic [COORD_W-1:0] in_pixel_x;
  logic [COORD_W-1:0] in_pixel_y;
  logic [BG_W-1:0]    in_background;
  logic               out_valid;
  logic               out_stall;
  logic [BG_W-1:0]    out_pixel;
  logic               out_covered;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  overlay_scoreboard sb = new();
  bit loaded [DEPTH];
  setting_t settings [N_SETTINGS];
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  cursor_overlay_blend_unit #(
    .CURSOR_SIDE(SIDE),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_image_index(in_image_index),
    .in_image_data (in_image_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_background (in_background),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_covered   (out_covered),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transaction monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item({in_op, in_image_index, in_image_data, in_pixel_x, in_pixel_y,
                    in_background});
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel, out_covered);
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic apply_setting(input setting_t s);
    reg_write(REG_LEFT, PDATA_W'(s.left));
    reg_write(REG_TOP, PDATA_W'(s.top));
    reg_write(REG_WIDTH, PDATA_W'(s.width));
    reg_write(REG_HEIGHT, PDATA_W'(s.height));
    reg_write(REG_FORMAT, PDATA_W'(s.fmt));
    reg_write(REG_KIND, PDATA_W'(s.kind));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input overlay_txn_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= t.op;
    in_image_index <= t.image_index;
    in_image_data <= t.image_data;
    in_pixel_x <= t.x;
    in_pixel_y <= t.y;
    in_background <= t.bg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic overlay_txn_t noise_txn();
    overlay_txn_t t;
    t.op = OP_PIXEL;
    t.image_index = IDX_W'($urandom);
    t.image_data = $urandom;
    t.x = COORD_W'($urandom);
    t.y = COORD_W'($urandom);
    t.bg = BG_W'($urandom);
    return t;
  endfunction

  function automatic logic [TEX_W-1:0] random_texel();
    logic [TEX_W-1:0] d;
    d = $urandom;
    case ($urandom_range(3))
      0: d[31:24] = 8'h00;
      1: d[31:24] = 8'hFF;
      2: d[31:24] = 8'h80;
      default: ;
    endcase
    return d;
  endfunction

  task automatic load_entry(input int idx, input logic [TEX_W-1:0] data);
    overlay_txn_t t;
    t = noise_txn();
    t.op = OP_LOAD;
    t.image_index = IDX_W'(idx);
    t.image_data = data;
    send_item(t);
    loaded[idx] = 1'b1;
  endtask

  // a covered pixel must never read an entry that was not loaded
  task automatic pixel_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [BG_W-1:0] bg);
    overlay_txn_t t;
    int entry;
    if (sb.lookup(x, y, entry) && !loaded[entry]) load_entry(entry, random_texel());
    t = noise_txn();
    t.x = x;
    t.y = y;
    t.bg = bg;
    send_item(t);
  endtask

  task automatic corner_pixels();
    int w;
    int h;
    w = sb.eff_width();
    h = sb.eff_height();
    pixel_at(COORD_W'(int'(sb.left)), COORD_W'(int'(sb.top)), FULL_BGR24);
    pixel_at(COORD_W'(int'(sb.left) + w), COORD_W'(int'(sb.top) + h - 1), '0);
  endtask

  task automatic random_item();
    int w;
    int h;
    int pick;
    int dx;
    int dy;
    w = sb.eff_width();
    h = sb.eff_height();
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(3) == 0 || w == 0 || h == 0) load_entry($urandom_range(DEPTH - 1),
                                                                 random_texel());
      else load_entry($urandom_range(h - 1) * SIDE + $urandom_range(w - 1), random_texel());
    end else if (pick < 88) begin
      if (pick < 60 && w > 0 && h > 0) begin
        dx = $urandom_range(w - 1);
        dy = $urandom_range(h - 1);
      end else begin
        dx = int'($urandom_range(w + 3)) - 2;
        dy = int'($urandom_range(h + 3)) - 2;
      end
      pixel_at(COORD_W'(int'(sb.left) + dx), COORD_W'(int'(sb.top) + dy), BG_W'($urandom));
    end else begin
      pixel_at(COORD_W'($urandom), COORD_W'($urandom), BG_W'($urandom));
    end
  endtask

  initial begin
    settings[0] = '{0, 0, 32, 32, FMT_BGR24, KIND_ALPHA, 0, 0};
    settings[1] = '{100, 50, 64, 64, FMT_RGB555, KIND_ALPHA, 74, 0};
    settings[2] = '{-10, -20, 17, 5, FMT_BGR24, KIND_MASK, 0, 74};
    settings[3] = '{4095, 4095, 1, 1, FMT_RGB555, KIND_MASK, 17, 17};
    settings[4] = '{-4096, -4096, 64, 64, FMT_BGR24, KIND_ALPHA, 0, 0};
    settings[5] = '{2000, 3000, 0, 100, FMT_BGR24, KIND_MASK, 74, 0};
    settings[6] = '{4032, 4032, 100, 64, FMT_RGB555, KIND_ALPHA, 0, 74};
    settings[7] = '{7, 3, 40, 23, FMT_BGR24, KIND_ALPHA, 17, 17};
    settings[8] = '{-1, 4000, 64, 1, FMT_RGB555, KIND_MASK, 0, 0};

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_LOAD;
    in_image_index <= '0;
    in_image_data <= '0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    in_background <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: 32x32 alpha cursor at the origin, 24-bit pixels
    load_entry(0, 32'hFFFF_FFFF);
    load_entry(1, 32'h8012_3456);
    load_entry(2, 32'h00AB_CDEF);
    load_entry(DEPTH - 1, 32'h0000_0000);
    pixel_at(12'd0, 12'd0, 24'h00_0000);
    pixel_at(12'd1, 12'd0, 24'hFF_FFFF);
    pixel_at(12'd2, 12'd0, 24'h12_3456);
    pixel_at(12'd31, 12'd31, 24'hFF_FFFF);
    pixel_at(12'd31, 12'd32, 24'hFF_FFFF);
    pixel_at(12'd4095, 12'd4095, 24'hFF_FFFF);
    pixel_at(12'd4095, 12'd0, 24'hAB_CDEF);

    for (int s = 0; s < N_SETTINGS; s++) begin
      if (s > 0) begin
        drain();
        apply_setting(settings[s]);
      end
      idle_pct = settings[s].idle_pct;
      stall_pct = settings[s].stall_pct;
      corner_pixels();
      repeat (RANDOM_PER_SETTING) random_item();
    end
    drain();

    $display("Ran %0d image loads and checked %0d pixels (%0d under the cursor)",
             sb.loads_seen, sb.checked, sb.covered_hits);
    $display("over %0d register settings with idle, stall and mixed pacing.", N_SETTINGS);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== cursor_overlay_blend_unit.f =====
+incdir+design
design/cob_pkg.sv
design/cob_ram.sv
design/cob_cfg.sv
design/cob_blend.sv
design/cursor_overlay_blend_unit.sv
test/testbench.sv
